// ----- sv/blg_pkg.sv -----
// Shared constants for the Bresenham line generator.
// Holds the line-kind codes, the command codes and the default coordinate width; no dependencies.
package blg_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // Line kind codes
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_OCT0 = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OCT1 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OCT6 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OCT7 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BACK = 3'd4;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

endpackage

// ----- sv/blg_classify.sv -----
// Load-time line setup: classifies the line and maps it into octant 0.
// Depends on blg_pkg for the line-kind codes.
module blg_classify #(
    parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0]   start_x,
    input  logic signed [COORD_BITS-1:0]   start_y,
    input  logic signed [COORD_BITS-1:0]   end_x,
    input  logic signed [COORD_BITS-1:0]   end_y,
    output logic [blg_pkg::KIND_W-1:0]     kind,
    output logic [COORD_BITS-1:0]          major,
    output logic [COORD_BITS-1:0]          minor,
    output logic signed [COORD_BITS+2:0]   dec_init,
    output logic                           active
);
    import blg_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] ndy;
    logic [COORD_BITS:0]        maj_w;
    logic [COORD_BITS:0]        mnr_w;

    // Form the end offset relative to the start
    assign dx  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign dy  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    assign ndy = -dy;

    // Pick the octant and the major and minor extents
    always_comb begin
        kind  = KIND_BACK;
        maj_w = '0;
        mnr_w = '0;
        if (dx < 0) begin
            kind = KIND_BACK;
        end else if (dy > 0) begin
            if (dy < dx) begin
                kind  = KIND_OCT0;
                maj_w = dx;
                mnr_w = dy;
            end else begin
                kind  = KIND_OCT1;
                maj_w = dy;
                mnr_w = dx;
            end
        end else if (ndy < dx) begin
            kind  = KIND_OCT7;
            maj_w = dx;
            mnr_w = ndy;
        end else begin
            kind  = KIND_OCT6;
            maj_w = ndy;
            mnr_w = dx;
        end
    end

    assign major    = maj_w[COORD_BITS-1:0];
    assign minor    = mnr_w[COORD_BITS-1:0];
    assign active   = (major != '0);

    // Initial error term 2*minor - major
    assign dec_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});

endmodule

// ----- sv/blg_point.sv -----
// Step logic: maps the current octant-0 position back to the line's octant
// and advances the error term. Depends on blg_pkg for the line-kind codes.
module blg_point #(
    parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]          origin_x,
    input  logic [COORD_BITS-1:0]          origin_y,
    input  logic [blg_pkg::KIND_W-1:0]     kind,
    input  logic [COORD_BITS-1:0]          major,
    input  logic [COORD_BITS-1:0]          minor,
    input  logic [COORD_BITS-1:0]          step_index,
    input  logic [COORD_BITS-1:0]          minor_pos,
    input  logic signed [COORD_BITS+2:0]   decision,
    output logic [COORD_BITS-1:0]          pt_x,
    output logic [COORD_BITS-1:0]          pt_y,
    output logic                           last,
    output logic [COORD_BITS-1:0]          step_index_next,
    output logic [COORD_BITS-1:0]          minor_pos_next,
    output logic signed [COORD_BITS+2:0]   decision_next
);
    import blg_pkg::*;

    logic signed [COORD_BITS+2:0] two_minor;
    logic signed [COORD_BITS+2:0] two_major;

    // Map the point back through the inverse octant transform
    always_comb begin
        unique case (kind)
            KIND_OCT1: begin
                pt_x = origin_x + minor_pos;
                pt_y = origin_y + step_index;
            end
            KIND_OCT6: begin
                pt_x = origin_x + minor_pos;
                pt_y = origin_y - step_index;
            end
            KIND_OCT7: begin
                pt_x = origin_x + step_index;
                pt_y = origin_y - minor_pos;
            end
            default: begin
                pt_x = origin_x + step_index;
                pt_y = origin_y + minor_pos;
            end
        endcase
    end

    assign step_index_next = step_index + 1'b1;
    assign last            = (step_index_next == major);

    // Advance the error term after the point is taken
    assign two_minor = $signed({2'b00, minor, 1'b0});
    assign two_major = $signed({2'b00, major, 1'b0});

    always_comb begin
        if (decision < 0) begin
            decision_next  = decision + two_minor;
            minor_pos_next = minor_pos;
        end else begin
            decision_next  = decision + two_minor - two_major;
            minor_pos_next = minor_pos + 1'b1;
        end
    end

endmodule

// ----- sv/bresenham_line_generator_core.sv -----
// Bresenham line generator: input item register, setup/step logic, result register.
// Each item passes through 2 register stages: the input item register, then the result register.
// Throughput: one item per cycle while the result channel is not stalled by m_tready.
// Reset (aresetn low, synchronous): clears both stage valids and all line state;
// a step before any load yields no point with line kind octant 0.
module bresenham_line_generator_core #(
    parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Input channel
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // s_tdata: start_x, start_y, end_x, end_y (lowest first), zero pad to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // s_tuser: cmd
    input  logic                                    s_tuser,
    // Result channel
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // m_tdata: pt_x, pt_y (lowest first), zero pad to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_tdata,
    // m_tuser: has_point, line_kind (lowest first)
    output logic [blg_pkg::KIND_W:0]                m_tuser,
    // m_tlast: last_point
    output logic                                    m_tlast
);
    import blg_pkg::*;

    localparam int C = COORD_BITS;

    // Input stage
    logic          in_valid_reg;
    logic          in_cmd_reg;
    logic [C-1:0]  in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;

    // Line state
    logic [C-1:0]          origin_x_reg, origin_x_next;
    logic [C-1:0]          origin_y_reg, origin_y_next;
    logic [KIND_W-1:0]     octant_sel_reg, octant_sel_next;
    logic [C-1:0]          major_len_reg, major_len_next;
    logic [C-1:0]          minor_delta_reg, minor_delta_next;
    logic [C-1:0]          step_index_reg, step_index_next;
    logic [C-1:0]          minor_pos_reg, minor_pos_next;
    logic signed [C+2:0]   decision_reg, decision_next;
    logic                  line_active_reg, line_active_next;

    // Result stage
    logic                  out_valid_reg;
    logic                  out_has_reg, out_has_next;
    logic [C-1:0]          out_x_reg, out_x_next;
    logic [C-1:0]          out_y_reg, out_y_next;
    logic                  out_last_reg, out_last_next;
    logic [KIND_W-1:0]     out_kind_reg, out_kind_next;

    // Setup and step results
    logic [KIND_W-1:0]     ld_kind;
    logic [C-1:0]          ld_major, ld_minor;
    logic signed [C+2:0]   ld_dec;
    logic                  ld_active;
    logic [C-1:0]          st_x, st_y, st_index, st_minor_pos;
    logic                  st_last;
    logic signed [C+2:0]   st_dec;

    logic advance;

    // Move the item forward when the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Capture input items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser;
            in_sx_reg  <= s_tdata[C-1:0];
            in_sy_reg  <= s_tdata[2*C-1:C];
            in_ex_reg  <= s_tdata[3*C-1:2*C];
            in_ey_reg  <= s_tdata[4*C-1:3*C];
        end
    end

    blg_classify #(
        .COORD_BITS (C)
    ) u_classify (
        .start_x  (in_sx_reg),
        .start_y  (in_sy_reg),
        .end_x    (in_ex_reg),
        .end_y    (in_ey_reg),
        .kind     (ld_kind),
        .major    (ld_major),
        .minor    (ld_minor),
        .dec_init (ld_dec),
        .active   (ld_active)
    );

    blg_point #(
        .COORD_BITS (C)
    ) u_point (
        .origin_x        (origin_x_reg),
        .origin_y        (origin_y_reg),
        .kind            (octant_sel_reg),
        .major           (major_len_reg),
        .minor           (minor_delta_reg),
        .step_index      (step_index_reg),
        .minor_pos       (minor_pos_reg),
        .decision        (decision_reg),
        .pt_x            (st_x),
        .pt_y            (st_y),
        .last            (st_last),
        .step_index_next (st_index),
        .minor_pos_next  (st_minor_pos),
        .decision_next   (st_dec)
    );

    // Select the next line state and result for the held item
    always_comb begin
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        octant_sel_next  = octant_sel_reg;
        major_len_next   = major_len_reg;
        minor_delta_next = minor_delta_reg;
        step_index_next  = step_index_reg;
        minor_pos_next   = minor_pos_reg;
        decision_next    = decision_reg;
        line_active_next = line_active_reg;
        out_has_next     = 1'b0;
        out_x_next       = '0;
        out_y_next       = '0;
        out_last_next    = 1'b0;
        out_kind_next    = octant_sel_reg;
        if (in_cmd_reg == CMD_LOAD) begin
            origin_x_next    = in_sx_reg;
            origin_y_next    = in_sy_reg;
            octant_sel_next  = ld_kind;
            major_len_next   = ld_major;
            minor_delta_next = ld_minor;
            step_index_next  = '0;
            minor_pos_next   = '0;
            decision_next    = ld_dec;
            line_active_next = ld_active;
            out_last_next    = !ld_active;
            out_kind_next    = ld_kind;
        end else if (line_active_reg) begin
            step_index_next  = st_index;
            minor_pos_next   = st_minor_pos;
            decision_next    = st_dec;
            line_active_next = !st_last;
            out_has_next     = 1'b1;
            out_x_next       = st_x;
            out_y_next       = st_y;
            out_last_next    = st_last;
        end
    end

    // Update line state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            octant_sel_reg  <= KIND_OCT0;
            major_len_reg   <= '0;
            minor_delta_reg <= '0;
            step_index_reg  <= '0;
            minor_pos_reg   <= '0;
            decision_reg    <= '0;
            line_active_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                origin_x_reg    <= origin_x_next;
                origin_y_reg    <= origin_y_next;
                octant_sel_reg  <= octant_sel_next;
                major_len_reg   <= major_len_next;
                minor_delta_reg <= minor_delta_next;
                step_index_reg  <= step_index_next;
                minor_pos_reg   <= minor_pos_next;
                decision_reg    <= decision_next;
                line_active_reg <= line_active_next;
            end
        end
        if (advance && in_valid_reg) begin
            out_has_reg  <= out_has_next;
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_last_reg <= out_last_next;
            out_kind_reg <= out_kind_next;
        end
    end

    // Drive the result channel
    always_comb begin
        m_tdata          = '0;
        m_tdata[C-1:0]   = out_x_reg;
        m_tdata[2*C-1:C] = out_y_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_kind_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- tb/tb_bresenham_line_generator_core.sv -----
// Self-checking testbench for bresenham_line_generator_core: directed lines in every
// rightward octant, then random lines and noise, with random idling on both stream channels.
// Depends on blg_pkg and the core; a tracker class predicts each result item.
module tb_bresenham_line_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import blg_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int SD_W      = ((4*CW+7)/8)*8;
    localparam int MD_W      = ((2*CW+7)/8)*8;
    localparam int IDLE_MAX  = 1000;
    localparam int RAND_ITEMS = 600;
    localparam int REPORT_MAX = 10;

    // One result item as seen on the master side
    typedef struct packed {
        logic                 has;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
        logic [KIND_W-1:0]    kind;
    } line_point_t;

    // Tracks the line state and queues the expected result of every accepted item
    class line_point_tracker;
        line_point_t       expected_points[$];
        longint            org_x = 0;
        longint            org_y = 0;
        logic [KIND_W-1:0] octant = KIND_OCT0;
        longint            major_len = 0;
        longint            minor_delta = 0;
        longint            step_idx = 0;
        longint            minor_pos = 0;
        longint            err_term = 0;
        bit                active = 0;
        int                mismatches = 0;
        int                points_checked = 0;
        int                lines_done = 0;

        function int pending();
            return expected_points.size();
        endfunction

        function int remaining();
            return active ? int'(major_len - step_idx) : 0;
        endfunction

        // Advance the line state by one accepted input item
        function void note_item(logic cmd, logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                                logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
            line_point_t p;
            longint      dx;
            longint      dy;
            longint      maj;
            longint      mnr;
            longint      px;
            longint      py;
            bit          fin;
            p = '0;
            if (cmd == CMD_LOAD) begin
                dx  = longint'(ex) - longint'(sx);
                dy  = longint'(ey) - longint'(sy);
                maj = 0;
                mnr = 0;
                // Sort into a rightward octant or call it backward
                if (dx < 0) begin
                    octant = KIND_BACK;
                end else if (dy > 0) begin
                    if (dy < dx) begin
                        octant = KIND_OCT0; maj = dx; mnr = dy;
                    end else begin
                        octant = KIND_OCT1; maj = dy; mnr = dx;
                    end
                end else if (-dy < dx) begin
                    octant = KIND_OCT7; maj = dx; mnr = -dy;
                end else begin
                    octant = KIND_OCT6; maj = -dy; mnr = dx;
                end
                org_x       = longint'(sx);
                org_y       = longint'(sy);
                major_len   = maj;
                minor_delta = mnr;
                step_idx    = 0;
                minor_pos   = 0;
                err_term    = 2 * mnr - maj;
                active      = (maj > 0);
                p.last      = !active;
                p.kind      = octant;
            end else if (!active) begin
                p.kind = octant;
            end else begin
                fin = (step_idx + 1 == major_len);
                // Map the octant-0 offset back into the line's own octant
                case (octant)
                    KIND_OCT1: begin px = org_x + minor_pos; py = org_y + step_idx;  end
                    KIND_OCT6: begin px = org_x + minor_pos; py = org_y - step_idx;  end
                    KIND_OCT7: begin px = org_x + step_idx;  py = org_y - minor_pos; end
                    default:   begin px = org_x + step_idx;  py = org_y + minor_pos; end
                endcase
                p.has  = 1'b1;
                p.x    = px[CW-1:0];
                p.y    = py[CW-1:0];
                p.last = fin;
                p.kind = octant;
                // Update the error term after the point goes out
                if (err_term < 0) begin
                    err_term += 2 * minor_delta;
                end else begin
                    minor_pos++;
                    err_term += 2 * (minor_delta - major_len);
                end
                step_idx++;
                if (fin) begin
                    active = 0;
                    lines_done++;
                end
            end
            expected_points = {expected_points, p};
        endfunction

        // Compare one accepted result item with the oldest expectation
        function void check_point(line_point_t got);
            line_point_t want;
            points_checked++;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected item has=%0b x=%0d y=%0d last=%0b kind=%0d",
                             got.has, got.x, got.y, got.last, got.kind);
                return;
            end
            want = expected_points.pop_front();
            if (got.has !== want.has || got.x !== want.x || got.y !== want.y ||
                got.last !== want.last || got.kind !== want.kind) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("ERROR: item %0d expected has=%0b x=%0d y=%0d last=%0b kind=%0d",
                             points_checked, want.has, want.x, want.y, want.last, want.kind);
                    $display("       got      has=%0b x=%0d y=%0d last=%0b kind=%0d",
                             got.has, got.x, got.y, got.last, got.kind);
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [SD_W-1:0]   s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [MD_W-1:0]   m_tdata;
    logic [KIND_W:0]   m_tuser;
    logic              m_tlast;

    line_point_tracker tracker;
    bit                no_gaps;
    bit                drained_mid;
    int                items_sent;
    int                loads_sent;
    int                steps_sent;
    int                idle_cycles;

    bresenham_line_generator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic cmd, input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                             input logic [CW-1:0] ex, input logic [CW-1:0] ey);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ey, ex, sy, sx};
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(cmd, sx, sy, ex, ey);
        items_sent++;
        if (cmd == CMD_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    task automatic load_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                             input logic [CW-1:0] ex, input logic [CW-1:0] ey);
        send_item(CMD_LOAD, sx, sy, ex, ey);
    endtask

    // Step fields carry random bits, which the block must ignore
    task automatic step_line(input int n);
        repeat (n)
            send_item(CMD_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
    endtask

    // Lower valid and hold off until every expected result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    // Accept one result item after a random stall
    task automatic take_result();
        int          gap;
        line_point_t got;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge aclk);
            m_tready <= 1'b0;
        end
        @(negedge aclk);
        m_tready <= 1'b1;
        do @(posedge aclk); while (!m_tvalid);
        got.has  = m_tuser[0];
        got.kind = m_tuser[KIND_W:1];
        got.x    = m_tdata[CW-1:0];
        got.y    = m_tdata[2*CW-1:CW];
        got.last = m_tlast;
        tracker.check_point(got);
    endtask

    // Result side
    initial begin
        @(posedge aresetn);
        forever take_result();
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("ERROR: no item moved for %0d cycles, %0d results outstanding",
                         IDLE_MAX, tracker.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int          pick;
        int          n;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        tracker     = new;
        no_gaps     = 1'b0;
        drained_mid = 1'b0;
        items_sent  = 0;
        loads_sent  = 0;
        steps_sent  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = CMD_LOAD;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: step before any load, then one short line per rightward octant
        step_line(1);
        load_line(16'sd0, 16'sd0, 16'sd4, 16'sd1);
        step_line(5);
        load_line(-16'sd3, 16'sd2, -16'sd2, 16'sd5);
        step_line(3);
        load_line(16'sd10, -16'sd10, 16'sd12, -16'sd13);
        step_line(3);
        load_line(16'sd7, 16'sd7, 16'sd10, 16'sd6);
        step_line(3);
        // Backward and zero-length lines give no points
        load_line(16'sd5, 16'sd5, 16'sd4, 16'sd9);
        load_line(16'sd3, 16'sd3, 16'sd3, 16'sd3);
        step_line(1);
        // Coordinate extremes on both diagonals
        load_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        step_line(2);
        load_line(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        step_line(2);
        load_line(16'h7fff, 16'h0000, 16'h8000, 16'hffff);

        // Random: mostly short whole lines, some long partial ones, some noise
        while (items_sent < RAND_ITEMS + 30) begin
            no_gaps = (items_sent >= 250 && items_sent < 350);
            if (items_sent >= 400 && !drained_mid) begin
                drain_results();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 9);
            sx   = CW'($urandom);
            sy   = CW'($urandom);
            if (pick <= 6) begin
                load_line(sx, sy, sx + CW'($urandom_range(0, 14) - 2),
                          sy + CW'($urandom_range(0, 24) - 12));
                n = tracker.remaining() + $urandom_range(0, 1);
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(0, n);
                step_line(n);
            end else if (pick == 7) begin
                load_line(sx, sy, CW'($urandom), CW'($urandom));
                n = tracker.remaining();
                step_line(n < 12 ? n : $urandom_range(0, 12));
            end else if (pick == 8) begin
                send_item(1'($urandom_range(0, 1)), sx, sy, CW'($urandom), CW'($urandom));
            end else begin
                step_line($urandom_range(1, 4));
            end
        end

        // Let the block run dry, then report
        drain_results();
        repeat (8) @(posedge aclk);
        $display("Covered %0d loads and %0d steps; %0d result items compared, %0d lines traced",
                 loads_sent, steps_sent, tracker.points_checked, tracker.lines_done);
        $display("to their last point, %0d mismatches", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
